[rtl/dast_pkg.sv]
// ----------------------------------------------------------------------------
// dast_pkg
// Types and codes shared by the device address slot table modules.
// ----------------------------------------------------------------------------
package dast_pkg;

  localparam int unsigned AddrWidth   = 48;
  localparam int unsigned ReqWidth    = 2;
  localparam int unsigned SlotInWidth = 4;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned SlotOutWidth = 3;

  // request codes
  localparam logic [ReqWidth-1:0] REQ_FIND  = 2'd0;
  localparam logic [ReqWidth-1:0] REQ_ALLOC = 2'd1;
  localparam logic [ReqWidth-1:0] REQ_FREE  = 2'd2;

  // response codes
  localparam logic [StatusWidth-1:0] STATUS_HIT       = 3'd0;
  localparam logic [StatusWidth-1:0] STATUS_ALLOCATED = 3'd1;
  localparam logic [StatusWidth-1:0] STATUS_MISS      = 3'd2;
  localparam logic [StatusWidth-1:0] STATUS_FULL      = 3'd3;
  localparam logic [StatusWidth-1:0] STATUS_FREED     = 3'd4;
  localparam logic [StatusWidth-1:0] STATUS_REJECTED  = 3'd5;

  // slot code that names no slot
  localparam logic [SlotInWidth-1:0] NULL_SLOT = 4'd8;

  typedef struct packed {
    logic [ReqWidth-1:0]    req_type;
    logic [AddrWidth-1:0]   device_address;
    logic [SlotInWidth-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [StatusWidth-1:0]  status;
    logic [SlotOutWidth-1:0] result_slot;
  } rsp_t;

  typedef struct packed {
    logic ld_req;
    logic cmp_en;
    logic upd_en;
  } dast_cmd_t;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_CMP,
    CTRL_UPD
  } ctrl_state_e;

endpackage

[rtl/dast_datapath.sv]
// ----------------------------------------------------------------------------
// dast_datapath
// Slot storage, parallel address compare, lowest-slot encode and response
// register.
// ----------------------------------------------------------------------------
module dast_datapath import dast_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dast_cmd_t cmd_i,
  input  req_t      req_i,
  output rsp_t      rsp_o
);

  localparam int unsigned IdxWidth = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned ExtWidth = 7;

  req_t                  req_q;
  logic [SLOT_COUNT-1:0] in_use_q;
  logic [AddrWidth-1:0]  slot_addr_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] match_d, match_q;
  logic [SLOT_COUNT-1:0] free_q;
  logic [IdxWidth-1:0]   hit_idx, free_idx, sel_idx;
  logic                  hit_any, free_any, free_ok;
  logic [ExtWidth-1:0]   sidx_ext;
  logic [IdxWidth-1:0]   rel_idx;
  logic                  set_en, clr_en;
  rsp_t                  rsp_d, rsp_q;

  // request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_q <= req_i;
    end
  end

  // parallel compare
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match_d[i] = in_use_q[i] && (slot_addr_q[i] == req_q.device_address);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      match_q <= match_d;
      free_q  <= ~in_use_q;
    end
  end

  // lowest set bit
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IdxWidth'(i);
      end
      if (free_q[i]) begin
        free_idx = IdxWidth'(i);
      end
    end
    hit_any  = |match_q;
    free_any = |free_q;
  end

  assign sidx_ext = ExtWidth'(req_q.slot_index);
  assign rel_idx  = sidx_ext[IdxWidth-1:0];
  assign free_ok  = (req_q.slot_index != NULL_SLOT) &&
                    (sidx_ext < ExtWidth'(SLOT_COUNT)) && in_use_q[rel_idx];

  always_comb begin
    rsp_d   = '{status: STATUS_MISS, result_slot: '0};
    set_en  = 1'b0;
    clr_en  = 1'b0;
    sel_idx = free_idx;
    case (req_q.req_type)
      REQ_FIND: begin
        if (hit_any) begin
          rsp_d.status      = STATUS_HIT;
          rsp_d.result_slot = SlotOutWidth'(ExtWidth'(hit_idx));
        end
      end
      REQ_ALLOC: begin
        if (hit_any) begin
          rsp_d.status      = STATUS_HIT;
          rsp_d.result_slot = SlotOutWidth'(ExtWidth'(hit_idx));
        end else if (free_any) begin
          rsp_d.status      = STATUS_ALLOCATED;
          rsp_d.result_slot = SlotOutWidth'(ExtWidth'(free_idx));
          set_en            = 1'b1;
        end else begin
          rsp_d.status = STATUS_FULL;
        end
      end
      REQ_FREE: begin
        sel_idx = rel_idx;
        if (free_ok) begin
          rsp_d.status      = STATUS_FREED;
          rsp_d.result_slot = SlotOutWidth'(sidx_ext);
          clr_en            = 1'b1;
        end else begin
          rsp_d.status = STATUS_REJECTED;
        end
      end
      default: begin
        rsp_d.status = STATUS_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (cmd_i.upd_en) begin
      if (set_en) begin
        in_use_q[sel_idx] <= 1'b1;
      end else if (clr_en) begin
        in_use_q[sel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en && set_en) begin
      slot_addr_q[sel_idx] <= req_q.device_address;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

[rtl/dast_ctrl.sv]
// ----------------------------------------------------------------------------
// dast_ctrl
// Sequencer for load, compare and update steps, plus response valid flag.
// ----------------------------------------------------------------------------
module dast_ctrl import dast_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output dast_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        out_free;

  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      CTRL_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.ld_req = 1'b1;
          state_d      = CTRL_CMP;
        end
      end
      CTRL_CMP: begin
        cmd_o.cmp_en = 1'b1;
        state_d      = CTRL_UPD;
      end
      CTRL_UPD: begin
        if (out_free) begin
          cmd_o.upd_en = 1'b1;
          req_ready_o  = 1'b1;
          if (req_valid_i) begin
            cmd_o.ld_req = 1'b1;
            state_d      = CTRL_CMP;
          end else begin
            state_d = CTRL_IDLE;
          end
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase

    if (cmd_o.upd_en) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == CTRL_CMP)
    else $error("accepted word did not enter compare");

  a_cmp_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CTRL_CMP |=> state_q == CTRL_UPD)
    else $error("compare not followed by update");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd_en |-> (!rsp_valid_q || rsp_ready_i))
    else $error("response overwritten before taken");

  a_cmp_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CTRL_CMP |-> !req_ready_o)
    else $error("ready during compare");

endmodule

[rtl/device_address_slot_table_core.sv]
// ----------------------------------------------------------------------------
// device_address_slot_table_core
// Associative slot table keyed by 48-bit device address: find, allocate and
// free requests, one response word per request.
// ----------------------------------------------------------------------------
// Each accepted request word is loaded into the request register; the compare
// step registers the parallel address compare against all slots in use; the
// update step picks the lowest matching or free slot (the named slot for a
// free), updates the table and loads the response register, and may take a
// new word while the response side keeps up; an untaken response holds it.
module device_address_slot_table_core import dast_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  logic req_valid_i,
  output logic req_ready_o,
  output rsp_t rsp_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i
);

  dast_cmd_t cmd;

  dast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .cmd_o       (cmd)
  );

  dast_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for device_address_slot_table_core. Find, allocate and
// free words are driven over the request channel with random gaps. Each
// accepted word runs through a behavioural copy of the slot table, and each
// response word is compared in order against the predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import dast_pkg::*;

  localparam int unsigned NumSlots    = 8;
  localparam logic [ReqWidth-1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned RandomWords = 1800;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned QuietFrom   = 2000;
  localparam int unsigned QuietTo     = 4000;
  localparam int unsigned PoolSize    = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  req_t req_i = '0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  rsp_t rsp_o;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;

  req_t        pending_words[$];
  rsp_t        awaited_rsps[$];
  int unsigned drain_points[$];
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  // table copy
  logic                 tbl_in_use [NumSlots];
  logic [AddrWidth-1:0] tbl_addr   [NumSlots];
  logic [AddrWidth-1:0] addr_pool  [PoolSize];

  device_address_slot_table_core #(
    .SLOT_COUNT(NumSlots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .rsp_o      (rsp_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [AddrWidth-1:0] random_address();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // lowest in-use slot holding the address, or NumSlots
  function automatic int unsigned matching_slot(logic [AddrWidth-1:0] addr);
    for (int unsigned i = 0; i < NumSlots; i++) begin
      if (tbl_in_use[i] && tbl_addr[i] == addr) return i;
    end
    return NumSlots;
  endfunction

  function automatic rsp_t apply_to_table(req_t w);
    rsp_t        r;
    int unsigned hit;
    r   = '{status: STATUS_MISS, result_slot: '0};
    hit = matching_slot(w.device_address);
    case (w.req_type)
      REQ_FIND: begin
        if (hit < NumSlots) r = '{status: STATUS_HIT, result_slot: hit[SlotOutWidth-1:0]};
      end
      REQ_ALLOC: begin
        if (hit < NumSlots) begin
          r = '{status: STATUS_HIT, result_slot: hit[SlotOutWidth-1:0]};
        end else begin
          r = '{status: STATUS_FULL, result_slot: '0};
          for (int unsigned i = 0; i < NumSlots; i++) begin
            if (!tbl_in_use[i]) begin
              tbl_in_use[i] = 1'b1;
              tbl_addr[i]   = w.device_address;
              r = '{status: STATUS_ALLOCATED, result_slot: i[SlotOutWidth-1:0]};
              break;
            end
          end
        end
      end
      REQ_FREE: begin
        if (w.slot_index == NULL_SLOT || w.slot_index >= NumSlots ||
            !tbl_in_use[w.slot_index]) begin
          r = '{status: STATUS_REJECTED, result_slot: '0};
        end else begin
          tbl_in_use[w.slot_index] = 1'b0;
          tbl_addr[w.slot_index]   = '0;
          r = '{status: STATUS_FREED, result_slot: w.slot_index[SlotOutWidth-1:0]};
        end
      end
      default: r = '{status: STATUS_MISS, result_slot: '0};
    endcase
    return r;
  endfunction

  task automatic queue_word(logic [ReqWidth-1:0] kind, logic [AddrWidth-1:0] addr,
                            logic [SlotInWidth-1:0] slot);
    pending_words.push_back('{req_type: kind, device_address: addr, slot_index: slot});
  endtask

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic idle_now;
    logic hold_now;
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
    end else begin
      if (req_valid_i && req_ready_o) begin
        awaited_rsps.push_back(apply_to_table(req_i));
        words_sent++;
      end
      if (!req_valid_i || req_ready_o) begin
        idle_now = (cycle_count < QuietFrom || cycle_count > QuietTo) &&
                   ($urandom_range(0, 99) < 25);
        hold_now = drain_points.size() > 0 && words_sent == drain_points[0];
        if (hold_now && awaited_rsps.size() == 0) begin
          void'(drain_points.pop_front());
          hold_now = 1'b0;
        end
        if (pending_words.size() > 0 && !idle_now && !hold_now) begin
          req_i       <= pending_words.pop_front();
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // response side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= (cycle_count >= QuietFrom && cycle_count <= QuietTo) ||
                     ($urandom_range(0, 99) >= 25);
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (awaited_rsps.size() == 0) begin
        $error("unexpected response word: status %0d slot %0d",
               rsp_o.status, rsp_o.result_slot);
        error_count++;
      end else begin
        want = awaited_rsps.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_o.status);
          error_count++;
        end
        if (rsp_o.result_slot !== want.result_slot) begin
          $error("result_slot: expected %0d, got %0d", want.result_slot, rsp_o.result_slot);
          error_count++;
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [ReqWidth-1:0] kind;
    int unsigned total_words;

    for (int unsigned i = 0; i < NumSlots; i++) begin
      tbl_in_use[i] = 1'b0;
      tbl_addr[i]   = '0;
    end
    for (int unsigned i = 0; i < PoolSize; i++) addr_pool[i] = random_address();

    // directed words
    queue_word(REQ_FIND, '0, 4'd0);
    queue_word(REQ_FREE, random_address(), NULL_SLOT);
    queue_word(REQ_FREE, '0, 4'd15);
    queue_word(REQ_FREE, '1, 4'd3);
    queue_word(REQ_ALLOC, '0, 4'd15);
    queue_word(REQ_ALLOC, '1, 4'd0);
    for (int unsigned i = 0; i < 6; i++) queue_word(REQ_ALLOC, addr_pool[i], 4'(i));
    queue_word(REQ_ALLOC, addr_pool[6], 4'd0);
    queue_word(REQ_ALLOC, '1, 4'd8);
    queue_word(REQ_FIND, '0, 4'd7);
    queue_word(REQ_FIND, '1, 4'd0);
    queue_word(REQ_UNKNOWN, addr_pool[0], 4'd1);
    queue_word(REQ_FREE, '0, 4'd0);
    queue_word(REQ_FIND, '0, 4'd0);
    queue_word(REQ_ALLOC, 48'h5555_5555_5555, 4'd0);
    queue_word(REQ_FREE, '0, 4'd9);
    queue_word(REQ_FREE, '0, 4'd7);
    queue_word(REQ_FREE, '0, 4'd7);
    queue_word(REQ_FIND, 48'h5555_5555_5555, 4'd2);
    drain_points.push_back(pending_words.size());
    drain_points.push_back(pending_words.size() + RandomWords / 2);

    // random part: mostly well-formed traffic on a small address pool
    for (int unsigned n = 0; n < RandomWords; n++) begin
      if ($urandom_range(0, 19) == 0) addr_pool[$urandom_range(0, PoolSize-1)] = random_address();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        case ($urandom_range(0, 2))
          0:       kind = REQ_FIND;
          1:       kind = REQ_ALLOC;
          default: kind = REQ_FREE;
        endcase
        queue_word(kind, addr_pool[$urandom_range(0, PoolSize-1)],
                   4'($urandom_range(0, NumSlots-1)));
      end else if (pick < 85) begin
        queue_word(REQ_UNKNOWN, random_address(), 4'($urandom));
      end else if (pick < 92) begin
        queue_word(REQ_FREE, random_address(), 4'($urandom_range(NumSlots, 15)));
      end else begin
        queue_word(2'($urandom), random_address(), 4'($urandom));
      end
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent != total_words || awaited_rsps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
